// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bitmap run allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg
// Types, codes and sizes shared by the bitmap run allocator modules.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int MAP_BITS   = 256;
  localparam int WORD_BITS  = 32;
  localparam int CHUNK_BITS = 8;

  localparam int NUM_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int NUM_CHUNKS = MAP_BITS / CHUNK_BITS;
  localparam int POS_W      = $clog2(MAP_BITS);
  localparam int LEN_W      = $clog2(MAP_BITS + 1);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int CHUNK_W    = $clog2(NUM_CHUNKS);
  localparam int CHUNK_LSB  = $clog2(CHUNK_BITS);

  localparam int FUNC_W    = 3;
  localparam int IDX_W     = 8;
  localparam int RUNLEN_W  = 9;
  localparam int POSN_W    = 8;
  localparam int CNT_W     = 9;
  localparam int POLICY_W  = 2;
  localparam int NBITS_W   = 9;
  localparam int CFG_W     = 9;
  localparam int REG_IDX_W = 1;
  localparam int CMP_W     = (LEN_W > RUNLEN_W) ? LEN_W : RUNLEN_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_MARK,
    FN_CLEAR,
    FN_TEST,
    FN_FIND,
    FN_FIT,
    FN_COUNT
  } func_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST,
    POL_BEST,
    POL_WORST
  } policy_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FIT_POLICY,
    REG_BITS_IN_USE
  } reg_idx_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [IDX_W-1:0]    bit_index;
    logic [RUNLEN_W-1:0] run_length;
  } bra_in_t;

  typedef struct packed {
    logic              found;
    logic [POSN_W-1:0] position;
    logic              bit_value;
    logic [CNT_W-1:0]  clear_count;
    logic              bad_index;
  } bra_out_t;

  typedef struct packed {
    logic load;
    logic single_op;
    logic scan_step;
    logic finish;
    logic deliver;
  } bra_cmd_t;

  typedef struct packed {
    logic is_single;
    logic is_scan;
    logic scan_last;
  } bra_stat_t;

endpackage

// ===== design/bra_ctrl.sv =====
// ----------------------------------------------------------------------------
// bra_ctrl
// Sequencer for the allocator: accepts an item, runs the single-bit
// operation or the chunk scan, closes the scan and hands over the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  bra_pkg::bra_stat_t  stat,
  output bra_pkg::bra_cmd_t   cmd
);
  import bra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SINGLE,
    S_SCAN,
    S_CLOSE,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_DECODE;
            in_ready <= 1'b0;
          end
        end
        S_DECODE: begin
          if (stat.is_single) begin
            state <= S_SINGLE;
          end else if (stat.is_scan) begin
            state <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SINGLE: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid && in_ready;
    cmd.single_op = (state == S_SINGLE);
    cmd.scan_step = (state == S_SCAN);
    cmd.finish    = (state == S_CLOSE);
    cmd.deliver   = (state == S_DONE) && out_free;
  end

  `CHK_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `CHK_NEXT(a_ready_after_deliver, clk, rst, cmd.deliver, in_ready, "not ready after result")

endmodule

// ===== design/bra_dp.sv =====
// ----------------------------------------------------------------------------
// bra_dp
// Bitmap storage and scan datapath: single-bit access, and a chunk-wide
// scan that tracks free runs, the first clear bit and the clear count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bra_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bra_pkg::bra_cmd_t             cmd,
  output bra_pkg::bra_stat_t            stat,
  input  bra_pkg::bra_in_t              in_data,
  input  logic [bra_pkg::POLICY_W-1:0]  fit_policy,
  input  logic [bra_pkg::LEN_W-1:0]     managed,
  output bra_pkg::bra_out_t             result
);
  import bra_pkg::*;

  logic [WORD_BITS-1:0] words [NUM_WORDS];

  logic [FUNC_W-1:0]   op_func;
  logic [IDX_W-1:0]    op_idx;
  logic [RUNLEN_W-1:0] op_need;
  logic [CHUNK_W-1:0]  chunk;
  logic [POS_W-1:0]    cur_start;
  logic [LEN_W-1:0]    cur_len;
  logic                have;
  logic [POS_W-1:0]    best_start;
  logic [LEN_W-1:0]    best_len;
  logic                ff_have;
  logic [POS_W-1:0]    ff_pos;
  logic [LEN_W-1:0]    cnt;
  logic                bit_value;
  logic                bad;

  logic [POS_W-1:0]      single_pos;
  logic [WADDR_W-1:0]    single_waddr;
  logic [BIT_W-1:0]      single_boff;
  logic                  single_bad;
  logic [POS_W-1:0]      base;
  logic [WORD_BITS-1:0]  scan_word;
  logic [CHUNK_BITS-1:0] scan_bits;
  logic [POS_W-1:0]      p;
  logic                  clr;
  logic [POS_W-1:0]      st_start;
  logic [LEN_W-1:0]      st_len;
  logic                  st_have;
  logic [POS_W-1:0]      st_bstart;
  logic [LEN_W-1:0]      st_blen;
  logic                  st_fhave;
  logic [POS_W-1:0]      st_fpos;
  logic [LEN_W-1:0]      st_cnt;
  logic                  close_take;

  function automatic logic run_take(input logic h, input logic [LEN_W-1:0] bl,
                                    input logic [LEN_W-1:0] l,
                                    input logic [RUNLEN_W-1:0] need,
                                    input logic [POLICY_W-1:0] pol);
    logic ok;
    logic take;
    ok = CMP_W'(l) >= CMP_W'(need);
    case (pol)
      POL_BEST:  take = ok && (!h || (l < bl));
      POL_WORST: take = ok && (!h || (l > bl));
      default:   take = ok && !h;
    endcase
    return take;
  endfunction

  assign single_pos   = POS_W'(op_idx);
  assign single_waddr = single_pos[POS_W-1:BIT_W];
  assign single_boff  = single_pos[BIT_W-1:0];
  assign single_bad   = 32'(op_idx) >= 32'(managed);

  always_comb begin
    base      = POS_W'({chunk, {CHUNK_LSB{1'b0}}});
    scan_word = words[base[POS_W-1:BIT_W]];
    scan_bits = scan_word[base[BIT_W-1:0] +: CHUNK_BITS];
    st_start  = cur_start;
    st_len    = cur_len;
    st_have   = have;
    st_bstart = best_start;
    st_blen   = best_len;
    st_fhave  = ff_have;
    st_fpos   = ff_pos;
    st_cnt    = cnt;
    p         = base;
    clr       = 1'b0;
    for (int j = 0; j < CHUNK_BITS; j++) begin
      p   = base + POS_W'(j);
      clr = (32'(p) < 32'(managed)) && !scan_bits[j];
      if (clr) begin
        if (st_len == '0) begin
          st_start = p;
        end
        st_len = st_len + LEN_W'(1);
        st_cnt = st_cnt + LEN_W'(1);
        if (!st_fhave) begin
          st_fhave = 1'b1;
          st_fpos  = p;
        end
      end else begin
        if ((st_len != '0) && run_take(st_have, st_blen, st_len, op_need, fit_policy)) begin
          st_have   = 1'b1;
          st_bstart = st_start;
          st_blen   = st_len;
        end
        st_len = '0;
      end
    end
  end

  assign close_take = (cur_len != '0) && run_take(have, best_len, cur_len, op_need, fit_policy);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        words[k] <= '0;
      end
    end else begin
      if (cmd.single_op && !single_bad &&
          ((op_func == FN_MARK) || (op_func == FN_CLEAR))) begin
        words[single_waddr][single_boff] <= (op_func == FN_MARK);
      end else if (cmd.finish && (op_func == FN_FIND) && ff_have) begin
        words[ff_pos[POS_W-1:BIT_W]][ff_pos[BIT_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have    <= 1'b0;
      ff_have <= 1'b0;
    end else if (cmd.load) begin
      op_func    <= in_data.func;
      op_idx     <= in_data.bit_index;
      op_need    <= (in_data.run_length == '0) ? RUNLEN_W'(1) : in_data.run_length;
      chunk      <= '0;
      cur_start  <= '0;
      cur_len    <= '0;
      have       <= 1'b0;
      best_start <= '0;
      best_len   <= '0;
      ff_have    <= 1'b0;
      ff_pos     <= '0;
      cnt        <= '0;
      bit_value  <= 1'b0;
      bad        <= 1'b0;
    end else if (cmd.single_op) begin
      bad <= single_bad;
      if (!single_bad && (op_func == FN_TEST)) begin
        bit_value <= words[single_waddr][single_boff];
      end
    end else if (cmd.scan_step) begin
      chunk      <= chunk + CHUNK_W'(1);
      cur_start  <= st_start;
      cur_len    <= st_len;
      have       <= st_have;
      best_start <= st_bstart;
      best_len   <= st_blen;
      ff_have    <= st_fhave;
      ff_pos     <= st_fpos;
      cnt        <= st_cnt;
    end else if (cmd.finish) begin
      cur_len <= '0;
      if (close_take) begin
        have       <= 1'b1;
        best_start <= cur_start;
        best_len   <= cur_len;
      end
    end
  end

  always_comb begin
    stat.is_single = (op_func == FN_MARK) || (op_func == FN_CLEAR) || (op_func == FN_TEST);
    stat.is_scan   = (op_func == FN_FIND) || (op_func == FN_FIT) || (op_func == FN_COUNT);
    stat.scan_last = (chunk == CHUNK_W'(NUM_CHUNKS - 1));
  end

  always_comb begin
    result             = '0;
    result.bit_value   = bit_value;
    result.bad_index   = bad;
    if (op_func == FN_FIND) begin
      result.found    = ff_have;
      result.position = POSN_W'(ff_pos);
    end else if (op_func == FN_FIT) begin
      result.found    = have;
      result.position = POSN_W'(best_start);
    end else if (op_func == FN_COUNT) begin
      result.clear_count = CNT_W'(cnt);
    end
  end

  `CHK_IMPL(a_best_fits, clk, rst, have, CMP_W'(best_len) >= CMP_W'(op_need), "chosen run too short")

endmodule

// ===== design/bitmap_run_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// Allocation bitmap with single-bit mark, clear and test, find-first-clear,
// first, best and worst fit run search, and clear-bit count.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Mark, clear and test go through the
// decode and single-bit states; find, fit search and count go through
// decode, the scan and the close state; the run tracker walks the bitmap
// eight bits per clock in the scan. A finished result sits in the
// output register, so the next item is accepted while it waits.

module bitmap_run_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bra_pkg::bra_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bra_pkg::bra_out_t             out_data,
  input  logic                          wr_en,
  input  logic [bra_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [bra_pkg::CFG_W-1:0]     wr_data
);
  import bra_pkg::*;

  logic [POLICY_W-1:0] fit_policy;
  logic [NBITS_W-1:0]  bits_in_use;
  logic [LEN_W-1:0]    managed;
  logic                out_free;
  bra_cmd_t            cmd;
  bra_stat_t           stat;
  bra_out_t            result;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POL_FIRST;
      bits_in_use <= NBITS_W'(MAP_BITS);
    end else if (wr_en) begin
      case (wr_index)
        REG_FIT_POLICY:  fit_policy  <= wr_data[POLICY_W-1:0];
        REG_BITS_IN_USE: bits_in_use <= wr_data[NBITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign managed = (32'(bits_in_use) > 32'(MAP_BITS)) ? LEN_W'(MAP_BITS) : LEN_W'(bits_in_use);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
      out_data  <= result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  bra_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .fit_policy (fit_policy),
    .managed    (managed),
    .result     (result)
  );

endmodule
